@@ rtl/csb_pkg.sv @@
package csb_pkg;

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      REG_FRAME_WIDTH      = 2'd0,
      REG_FRAME_HEIGHT     = 2'd1,
      REG_TRANSPARENT_MASK = 2'd2
   } csb_reg_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int SIDE_W      = 11;
   localparam int MASK_W      = 32;
   localparam int COLOR_W     = 5;
   localparam int ADDR_W      = 20;
   localparam int PROD_W      = 2 * SIDE_W;

   localparam logic [SIDE_W-1:0] FRAME_WIDTH_RST  = 11'd128;
   localparam logic [SIDE_W-1:0] FRAME_HEIGHT_RST = 11'd128;
   localparam logic [MASK_W-1:0] MASK_RST         = 32'h0000_0001;

   // Frame sides above this saturate to it
   localparam int FRAME_SIDE_MAX = 1024;
   // Tint code that means "keep the source color"
   localparam logic [COLOR_W-1:0] TINT_KEEP = 5'd7;

   localparam int QUEUE_DEPTH = 2;

   // One classified pixel, as handed from the front to the back
   typedef struct packed {
      logic                  write_enable;
      logic                  sprite_done;
      logic [COLOR_W-1:0]    color;
      logic [SIDE_W-1:0]     dest_x;
      logic [SIDE_W-1:0]     dest_y;
      logic [SIDE_W-1:0]     stride;
   } csb_entry_type;

endpackage

@@ rtl/clipped_sprite_blit.sv @@
// Path: a word accepted on req_* is written into the queue, then registered in the multiply stage
//   and the output stage before it shows on rsp_*.
// Throughput: one word per cycle while the queue has room; the front classifies in the accept cycle,
//   the back registers the row-times-stride product in the multiply stage and the sum in the output stage.
// Reset (synchronous, active high): empties the queue and both back stages,
//   zeroes the sprite counters and loads frame 128x128 with color 0 transparent.
module clipped_sprite_blit import csb_pkg::*; #(
   parameter int MAX_SPRITE_SIDE = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   // pixel input
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_pixel_value,
   input  logic                     req_first_pixel,
   input  logic                     req_last_pixel,
   input  logic signed [11:0]       req_origin_x,
   input  logic signed [11:0]       req_origin_y,
   input  logic [8:0]               req_sprite_width,
   input  logic signed [6:0]        req_tint_color,
   // framebuffer write output
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_write_enable,
   output logic [ADDR_W-1:0]        rsp_write_address,
   output logic [COLOR_W-1:0]       rsp_write_color,
   output logic                     rsp_sprite_done,
   // configuration writes
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   logic [SIDE_W-1:0]  frame_width_ff, frame_height_ff;
   logic [MASK_W-1:0]  mask_ff;

   logic               push, pop, queue_full, queue_not_empty;
   csb_entry_type      push_entry, head;

   // Configuration registers: take each write at once, ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         mask_ff         <= MASK_RST;
      end else if (csr_we) begin
         unique case (csb_reg_type'(csr_index))
            REG_FRAME_WIDTH:      frame_width_ff  <= csr_wdata[SIDE_W-1:0];
            REG_FRAME_HEIGHT:     frame_height_ff <= csr_wdata[SIDE_W-1:0];
            REG_TRANSPARENT_MASK: mask_ff         <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Front: track column and row, clip against the frame, apply color key
   // and tint. A word is taken whenever the queue has room, so the input
   // keeps flowing while a finished result waits on rsp_ready, until the queue fills.
   csb_front #(
      .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .req_first_pixel  (req_first_pixel),
      .req_last_pixel   (req_last_pixel),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_sprite_width (req_sprite_width),
      .req_tint_color   (req_tint_color),
      .frame_width      (frame_width_ff),
      .frame_height     (frame_height_ff),
      .transparent_mask (mask_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // Short queue: lets the front and back stall independently
   csb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   // Back: form the address row * stride + column and hold the result
   csb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_not_empty   (queue_not_empty),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_address (rsp_write_address),
      .rsp_write_color   (rsp_write_color),
      .rsp_sprite_done   (rsp_sprite_done)
   );

endmodule

@@ rtl/csb_front.sv @@
module csb_front import csb_pkg::*; #(
   parameter int MAX_SPRITE_SIDE = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_pixel_value,
   input  logic                 req_first_pixel,
   input  logic                 req_last_pixel,
   input  logic signed [11:0]   req_origin_x,
   input  logic signed [11:0]   req_origin_y,
   input  logic [8:0]           req_sprite_width,
   input  logic signed [6:0]    req_tint_color,
   input  logic [SIDE_W-1:0]    frame_width,
   input  logic [SIDE_W-1:0]    frame_height,
   input  logic [MASK_W-1:0]    transparent_mask,
   input  logic                 queue_full,
   output logic                 push,
   output csb_entry_type        push_entry
);

   localparam int CW   = $clog2(MAX_SPRITE_SIDE);
   localparam int CMPW = (CW + 1 > 9) ? CW + 1 : 9;
   localparam int DW   = ((CW + 1 > 12) ? CW + 1 : 12) + 1;
   localparam int SatLimit = (FRAME_SIDE_MAX > 2047) ? 2047 : FRAME_SIDE_MAX;

   logic [CW-1:0]      col_ff, col_in, row_ff, row_in;
   logic [CW-1:0]      cur_col, cur_row;
   logic [CMPW-1:0]    next_col;
   logic               wrap;
   logic [SIDE_W-1:0]  fw, fh;
   logic [DW-1:0]      dx, dy;
   logic               in_frame, opaque, we, use_tint;
   logic [COLOR_W-1:0] color;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      fw = (frame_width  > SIDE_W'(SatLimit)) ? SIDE_W'(SatLimit) : frame_width;
      fh = (frame_height > SIDE_W'(SatLimit)) ? SIDE_W'(SatLimit) : frame_height;

      cur_col = req_first_pixel ? '0 : col_ff;
      cur_row = req_first_pixel ? '0 : row_ff;

      dx = {{(DW-12){req_origin_x[11]}}, req_origin_x} + {{(DW-CW){1'b0}}, cur_col};
      dy = {{(DW-12){req_origin_y[11]}}, req_origin_y} + {{(DW-CW){1'b0}}, cur_row};

      in_frame = !dx[DW-1] && !dy[DW-1]
                 && (dx < {{(DW-SIDE_W){1'b0}}, fw})
                 && (dy < {{(DW-SIDE_W){1'b0}}, fh});
      opaque = !transparent_mask[req_pixel_value[COLOR_W-1:0]];
      we     = in_frame && opaque;

      use_tint = !req_tint_color[6] && !req_tint_color[5]
                 && (req_tint_color[4:0] != TINT_KEEP);
      color    = use_tint ? req_tint_color[4:0] : req_pixel_value[COLOR_W-1:0];

      // Zero the fields of a dropped pixel so the back produces a zero address
      push_entry.write_enable = we;
      push_entry.sprite_done  = req_last_pixel;
      push_entry.color        = we ? color : '0;
      push_entry.dest_x       = we ? dx[SIDE_W-1:0] : '0;
      push_entry.dest_y       = we ? dy[SIDE_W-1:0] : '0;
      push_entry.stride       = we ? fw : '0;

      // Advance the raster counters
      next_col = CMPW'(cur_col) + CMPW'(1);
      wrap     = (next_col >= CMPW'(req_sprite_width))
                 || (next_col >= CMPW'(MAX_SPRITE_SIDE));
      if (req_last_pixel) begin
         col_in = '0;
         row_in = '0;
      end else if (wrap) begin
         col_in = '0;
         row_in = (cur_row == CW'(MAX_SPRITE_SIDE - 1)) ? '0 : cur_row + CW'(1);
      end else begin
         col_in = next_col[CW-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ rtl/csb_queue.sv @@
module csb_queue import csb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  csb_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output csb_entry_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   csb_entry_type        mem [QUEUE_DEPTH];
   logic [PW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]          count_ff, count_in;

   assign full      = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/csb_back.sv @@
module csb_back import csb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_not_empty,
   input  csb_entry_type       head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_write_enable,
   output logic [ADDR_W-1:0]   rsp_write_address,
   output logic [COLOR_W-1:0]  rsp_write_color,
   output logic                rsp_sprite_done
);

   // multiply stage
   logic                s1_valid_ff;
   logic [PROD_W-1:0]   s1_prod_ff;
   logic [SIDE_W-1:0]   s1_x_ff;
   logic [COLOR_W-1:0]  s1_color_ff;
   logic                s1_we_ff, s1_done_ff;
   // output stage
   logic                s2_valid_ff;
   logic [ADDR_W-1:0]   s2_addr_ff;
   logic [COLOR_W-1:0]  s2_color_ff;
   logic                s2_we_ff, s2_done_ff;
   logic                s1_move, s2_move;
   logic [PROD_W:0]     addr_sum;

   assign s2_move = !s2_valid_ff || rsp_ready;
   assign s1_move = !s1_valid_ff || s2_move;
   assign pop     = queue_not_empty && s1_move;

   assign addr_sum = {1'b0, s1_prod_ff} + (PROD_W+1)'(s1_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            s1_valid_ff <= queue_not_empty;
         end
         if (s2_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_prod_ff  <= PROD_W'(head.dest_y) * PROD_W'(head.stride);
         s1_x_ff     <= head.dest_x;
         s1_color_ff <= head.color;
         s1_we_ff    <= head.write_enable;
         s1_done_ff  <= head.sprite_done;
      end
      if (s2_move && s1_valid_ff) begin
         s2_addr_ff  <= addr_sum[ADDR_W-1:0];
         s2_color_ff <= s1_color_ff;
         s2_we_ff    <= s1_we_ff;
         s2_done_ff  <= s1_done_ff;
      end
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_write_enable  = s2_we_ff;
   assign rsp_write_address = s2_addr_ff;
   assign rsp_write_color   = s2_color_ff;
   assign rsp_sprite_done   = s2_done_ff;

endmodule

@@ rtl/clipped_sprite_blit_checker.sv @@
module clipped_sprite_blit_checker import csb_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_write_enable,
   input logic [ADDR_W-1:0]        rsp_write_address,
   input logic [COLOR_W-1:0]       rsp_write_color,
   input logic                     rsp_sprite_done
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_enable)
         && $stable(rsp_write_address) && $stable(rsp_write_color)
         && $stable(rsp_sprite_done))
      else $error("stalled result changed");

   // A dropped pixel carries a zero address and color
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_address == '0 && rsp_write_color == '0)
      else $error("dropped pixel has nonzero fields");

   // Reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // No result is valid right after reset is released
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result appeared without an accepted word");

endmodule

bind clipped_sprite_blit clipped_sprite_blit_checker u_checker (.*);

@@ dv/clipped_sprite_blit_tb.sv @@
module clipped_sprite_blit_tb;
   import csb_pkg::*;

   localparam int SPRITE_SIDE = 256;
   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_LIMIT = 10000;
   localparam int TIMEOUT = 6_000_000;
   localparam int PHASES = 5;
   localparam int PHASE_WORDS = 60;
   localparam int LONG_WORDS = 262;
   localparam int COLOR_MAX = (1 << COLOR_W) - 1;
   localparam int SIDE_ALL = (1 << SIDE_W) - 1;

   // One pixel word as it crosses the req_ channel
   typedef struct packed {
      logic [7:0]  pixel_value;
      logic        first_pixel;
      logic        last_pixel;
      logic [11:0] origin_x;
      logic [11:0] origin_y;
      logic [8:0]  sprite_width;
      logic [6:0]  tint_color;
   } pixel_word_type;

   // One framebuffer write word as it leaves on the rsp_ channel
   typedef struct packed {
      logic               write_enable;
      logic [ADDR_W-1:0]  write_address;
      logic [COLOR_W-1:0] write_color;
      logic               sprite_done;
   } fb_write_type;

   typedef enum logic {STIM_PIXEL, STIM_REG} stim_kind_type;

   // Directed table row: either a register write or a pixel word, the latter
   // optionally with its framebuffer write spelled out by hand
   typedef struct {
      stim_kind_type  kind;
      csb_reg_type    reg_sel;
      logic [31:0]    reg_value;
      pixel_word_type word;
      logic           pinned;
      fb_write_type   result;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_pixel_value = '0;
   logic                    req_first_pixel = 1'b0;
   logic                    req_last_pixel = 1'b0;
   logic signed [11:0]      req_origin_x = '0;
   logic signed [11:0]      req_origin_y = '0;
   logic [8:0]              req_sprite_width = '0;
   logic signed [6:0]       req_tint_color = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_write_enable;
   logic [ADDR_W-1:0]       rsp_write_address;
   logic [COLOR_W-1:0]      rsp_write_color;
   logic                    rsp_sprite_done;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Hand-typed expectation that travels alongside the word on the req_ side
   logic         req_pin = 1'b0;
   fb_write_type req_pin_write = '0;

   // Stall knobs: steady means no idling on that side
   logic req_steady = 1'b0;
   logic rsp_steady = 1'b0;
   int   rsp_hold = 0;

   // Blitter mirror: register copies and the sprite position counters
   logic [SIDE_W-1:0] fb_width = FRAME_WIDTH_RST;
   logic [SIDE_W-1:0] fb_height = FRAME_HEIGHT_RST;
   logic [MASK_W-1:0] key_mask = MASK_RST;
   logic [7:0]        col_pos = '0;
   logic [7:0]        row_pos = '0;

   fb_write_type pending_writes[$];
   stim_row_type dir_rows[$];

   int n_errors = 0;
   int n_sent = 0;
   int n_reg_writes = 0;
   int n_fb_writes = 0;
   int n_sprite_ends = 0;
   int n_clipped = 0;
   int n_keyed = 0;

   clipped_sprite_blit #(.MAX_SPRITE_SIDE(SPRITE_SIDE)) i_dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // Blit one pixel: locate it, clip it against the frame, apply the color
   // key and the tint, then advance the sprite counters.
   function automatic fb_write_type blit_pixel(input pixel_word_type w);
      fb_write_type       res;
      logic [COLOR_W-1:0] color;
      int                 dx, dy, fwe, fhe, tint, lin, next_col;
      logic               in_frame, opaque;
      color = w.pixel_value[COLOR_W-1:0];
      if (w.first_pixel) begin
         col_pos = '0;
         row_pos = '0;
      end
      // Frame sides beyond the maximum saturate
      fwe = int'(fb_width);
      if (fwe > FRAME_SIDE_MAX) fwe = FRAME_SIDE_MAX;
      fhe = int'(fb_height);
      if (fhe > FRAME_SIDE_MAX) fhe = FRAME_SIDE_MAX;
      dx = int'($signed(w.origin_x)) + int'(col_pos);
      dy = int'($signed(w.origin_y)) + int'(row_pos);
      in_frame = dx >= 0 && dy >= 0 && dx < fwe && dy < fhe;
      // Key on the source color, before any tint
      opaque = !key_mask[color];
      if (!in_frame) n_clipped++;
      else if (!opaque) n_keyed++;
      tint = int'($signed(w.tint_color));
      if (tint >= 0 && tint <= COLOR_MAX && tint != int'(TINT_KEEP)) color = tint[COLOR_W-1:0];
      lin = dy * fwe + dx;
      res.write_enable = in_frame && opaque;
      res.write_address = res.write_enable ? lin[ADDR_W-1:0] : '0;
      res.write_color = res.write_enable ? color : '0;
      res.sprite_done = w.last_pixel;
      // Advance: end of sprite clears both counters, else step the column
      // and wrap to the next row at the sprite width or the counter limit
      if (w.last_pixel) begin
         col_pos = '0;
         row_pos = '0;
      end else begin
         next_col = int'(col_pos) + 1;
         if (next_col >= int'(w.sprite_width) || next_col >= SPRITE_SIDE) begin
            col_pos = '0;
            row_pos = row_pos + 8'd1;
         end else begin
            col_pos = next_col[7:0];
         end
      end
      return res;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 93) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Frame side in the low bits, sometimes with junk above the register width
   function automatic logic [31:0] pick_side();
      logic [31:0] side;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: side = $urandom_range(1, 40);
         6:                side = 0;
         7:                side = FRAME_SIDE_MAX;
         8:                side = $urandom_range(FRAME_SIDE_MAX + 1, SIDE_ALL);
         default:          side = $urandom_range(1, FRAME_SIDE_MAX);
      endcase
      if ($urandom_range(0, 1) != 0) side = side | ($urandom() & ~32'(SIDE_ALL));
      return side;
   endfunction

   function automatic logic [31:0] pick_mask();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4, 5:       return 32'h1 << $urandom_range(0, 31);
         6, 7:       return '0;
         8:          return '1;
         default:    return $urandom() & $urandom();
      endcase
   endfunction

   function automatic stim_row_type pixel_row(input logic [7:0] value, input bit first,
                                              input bit last, input int ox, input int oy,
                                              input int sw, input int tint);
      stim_row_type row;
      row.kind = STIM_PIXEL;
      row.reg_sel = REG_FRAME_WIDTH;
      row.reg_value = '0;
      row.word.pixel_value = value;
      row.word.first_pixel = first;
      row.word.last_pixel = last;
      row.word.origin_x = ox[11:0];
      row.word.origin_y = oy[11:0];
      row.word.sprite_width = sw[8:0];
      row.word.tint_color = tint[6:0];
      row.pinned = 1'b0;
      row.result = '0;
      return row;
   endfunction

   function automatic stim_row_type known_row(input logic [7:0] value, input bit first,
                                              input bit last, input int ox, input int oy,
                                              input int sw, input int tint, input bit we,
                                              input int addr, input int color,
                                              input bit done);
      stim_row_type row;
      row = pixel_row(value, first, last, ox, oy, sw, tint);
      row.pinned = 1'b1;
      row.result = {we, addr[ADDR_W-1:0], color[COLOR_W-1:0], done};
      return row;
   endfunction

   function automatic stim_row_type reg_row(input csb_reg_type sel, input logic [31:0] value);
      stim_row_type row;
      row = pixel_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0);
      row.kind = STIM_REG;
      row.reg_sel = sel;
      row.reg_value = value;
      return row;
   endfunction

   // Hold req_valid low until every expected write has come back or the drain
   // limit runs out, then let the pipe settle. Check at the falling edge so the
   // queue is stable.
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Write one register with the block idle; mirror it in the same step
   task automatic write_reg(input csb_reg_type sel, input logic [31:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      case (sel)
         REG_FRAME_WIDTH:      fb_width = value[SIDE_W-1:0];
         REG_FRAME_HEIGHT:     fb_height = value[SIDE_W-1:0];
         REG_TRANSPARENT_MASK: key_mask = value[MASK_W-1:0];
         default: ;
      endcase
      n_reg_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one word, after an optional gap, and hold it until accepted.
   // Return in the accept step with valid still high.
   task automatic push_pixel(input pixel_word_type w, input logic pin,
                             input fb_write_type pin_write);
      int gap;
      gap = 0;
      if (!req_steady && $urandom_range(0, 99) < 30) gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= w.pixel_value;
      req_first_pixel <= w.first_pixel;
      req_last_pixel <= w.last_pixel;
      req_origin_x <= w.origin_x;
      req_origin_y <= w.origin_y;
      req_sprite_width <= w.sprite_width;
      req_tint_color <= w.tint_color;
      req_pin <= pin;
      req_pin_write <= pin_write;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
   endtask

   // Stream one sprite. Mostly well formed: fixed origin, width and tint,
   // first flag on the opening word and last flag on the closing one.
   // The rest drop a flag or are pure noise. A long sprite runs past the
   // counter limit so columns or rows wrap.
   task automatic play_sprite(input bit long_run);
      pixel_word_type w;
      logic [63:0]    noise;
      int             shape, sw, n, span, fwe, fhe, ox, oy, tint;
      shape = long_run ? 0 : $urandom_range(0, 99);
      fwe = int'(fb_width);
      if (fwe > FRAME_SIDE_MAX) fwe = FRAME_SIDE_MAX;
      fhe = int'(fb_height);
      if (fhe > FRAME_SIDE_MAX) fhe = FRAME_SIDE_MAX;
      if (long_run) begin
         sw = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1) : $urandom_range(257, 511);
         n = LONG_WORDS;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: sw = $urandom_range(1, 12);
            7:                   sw = 0;
            8:                   sw = $urandom_range(13, 40);
            default:             sw = $urandom_range(257, 511);
         endcase
         n = ((sw == 0) ? 1 : sw) * $urandom_range(1, 5);
         if (n > 48) n = $urandom_range(8, 48);
      end
      // Aim the origin around the frame edges so clipping happens on all sides
      span = ((sw > 40) ? 40 : sw) + 2;
      ox = $urandom_range(0, fwe + 2 * span) - span;
      oy = long_run ? $urandom_range(0, 64) - 8 : $urandom_range(0, fhe + 8) - 6;
      if ($urandom_range(0, 4) == 0) ox = $urandom_range(0, 4095) - 2048;
      if ($urandom_range(0, 4) == 0) oy = $urandom_range(0, 4095) - 2048;
      case ($urandom_range(0, 3))
         0, 1:    tint = -1;
         2:       tint = $urandom_range(0, COLOR_MAX);
         default: tint = $urandom_range(0, 127);
      endcase
      for (int k = 0; k < n; k++) begin
         if (shape >= 90) begin
            noise = {$urandom(), $urandom()};
            w = noise[$bits(pixel_word_type)-1:0];
         end else begin
            w.pixel_value = 8'($urandom_range(0, 255));
            w.first_pixel = (k == 0) && !(shape >= 75 && shape < 83);
            w.last_pixel = (k == n - 1) && !(shape >= 83 && shape < 90);
            w.origin_x = ox[11:0];
            w.origin_y = oy[11:0];
            w.sprite_width = sw[8:0];
            w.tint_color = tint[6:0];
         end
         push_pixel(w, 1'b0, '0);
      end
   endtask

   // Receiver: random stalls of random length, none while steady
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (!rsp_steady && $urandom_range(0, 99) < 25) begin
         rsp_ready <= 1'b0;
         rsp_hold <= idle_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Scoreboard: check each write word against the oldest expectation, then
   // queue the prediction for any pixel word accepted at this edge.
   always @(posedge clock) begin
      fb_write_type   got;
      fb_write_type   want;
      pixel_word_type word;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_write_enable, rsp_write_address, rsp_write_color, rsp_sprite_done};
            if (got.write_enable === 1'b1) n_fb_writes++;
            if (got.sprite_done === 1'b1) n_sprite_ends++;
            if (pending_writes.size() == 0) begin
               n_errors++;
               $error("write word with nothing expected: %h", got);
            end else begin
               want = pending_writes.pop_front();
               if (got.write_enable !== want.write_enable) begin
                  n_errors++;
                  $error("write_enable: expected %0d, got %0d",
                         want.write_enable, got.write_enable);
               end
               if (got.write_address !== want.write_address) begin
                  n_errors++;
                  $error("write_address: expected %0d, got %0d",
                         want.write_address, got.write_address);
               end
               if (got.write_color !== want.write_color) begin
                  n_errors++;
                  $error("write_color: expected %0d, got %0d",
                         want.write_color, got.write_color);
               end
               if (got.sprite_done !== want.sprite_done) begin
                  n_errors++;
                  $error("sprite_done: expected %0d, got %0d",
                         want.sprite_done, got.sprite_done);
               end
            end
         end
         if (req_valid && req_ready) begin
            word = {req_pixel_value, req_first_pixel, req_last_pixel, req_origin_x,
                    req_origin_y, req_sprite_width, req_tint_color};
            // Always run the mirror so its counters stay in step
            want = blit_pixel(word);
            if (req_pin) want = req_pin_write;
            pending_writes.push_back(want);
         end
      end
   end

   initial begin
      int phase_start;
      bit paused;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      dir_rows = '{
         // Reset state: 128x128 frame, color 0 keyed out
         known_row(8'h03, 1, 0, 0, 0, 4, -1, 1, 0, 3, 0),
         known_row(8'hE0, 0, 0, 0, 0, 4, -1, 0, 0, 0, 0),
         // Right edge: last column inside, tint 7 keeps the source color
         known_row(8'hFF, 0, 0, 125, 0, 4, 7, 1, 127, 31, 0),
         // One past the right edge, end of sprite
         known_row(8'h05, 0, 1, 125, 0, 4, 31, 0, 0, 0, 1),
         // Bottom-right corner, then one row below it
         known_row(8'h1F, 1, 0, 127, 127, 1, 63, 1, 16383, 31, 0),
         known_row(8'h9F, 0, 1, 127, 127, 1, 0, 0, 0, 0, 1),
         // New sprite without a first flag starts at its origin, left of frame
         known_row(8'h02, 0, 0, -1, 0, 3, 0, 0, 0, 0, 0),
         pixel_row(8'h02, 0, 0, -1, 0, 3, 0),
         // Restart mid-sprite, then a pixel above the frame
         pixel_row(8'h0A, 1, 0, 3, 3, 3, -1),
         pixel_row(8'h42, 0, 1, -1, -1, 3, 6),
         // Saturated width with zero height: everything clipped
         reg_row(REG_FRAME_WIDTH, SIDE_ALL),
         reg_row(REG_FRAME_HEIGHT, 0),
         pixel_row(8'h11, 1, 1, 0, 0, 8, -1),
         reg_row(REG_FRAME_HEIGHT, SIDE_ALL),
         reg_row(REG_FRAME_WIDTH, 0),
         pixel_row(8'h11, 1, 1, 0, 0, 8, -1),
         // Largest frame, nothing keyed: top address, zero sprite width
         reg_row(REG_FRAME_WIDTH, FRAME_SIDE_MAX),
         reg_row(REG_FRAME_HEIGHT, FRAME_SIDE_MAX),
         reg_row(REG_TRANSPARENT_MASK, 0),
         known_row(8'h00, 1, 0, 1023, 1023, 0, -64, 1, 20'hFFFFF, 0, 0),
         pixel_row(8'hE7, 0, 0, 1023, 1022, 0, 32),
         pixel_row(8'hA5, 0, 1, 2047, -2048, 511, 15),
         pixel_row(8'h7B, 1, 0, -2048, 2047, 256, -1),
         pixel_row(8'h80, 0, 1, 1000, 5, 300, 31),
         // Every color keyed out
         reg_row(REG_TRANSPARENT_MASK, 32'hFFFF_FFFF),
         known_row(8'h3C, 1, 1, 10, 10, 5, 3, 0, 0, 0, 1),
         reg_row(REG_TRANSPARENT_MASK, 32'h8000_0001),
         pixel_row(8'hFF, 1, 0, 0, 0, 2, -1),
         pixel_row(8'h60, 0, 1, 0, 0, 2, 12)
      };

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == STIM_REG)
            write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_value);
         else
            push_pixel(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].result);
      end

      // Random phases, each with its own frame and key. One phase runs with
      // no idling on either side; two open with a sprite long enough to wrap.
      paused = 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         req_steady <= (phase == 2);
         rsp_steady <= (phase == 2);
         case (phase)
            1: begin
               write_reg(REG_FRAME_WIDTH, FRAME_SIDE_MAX);
               write_reg(REG_FRAME_HEIGHT, FRAME_SIDE_MAX);
            end
            3: begin
               write_reg(REG_FRAME_WIDTH, $urandom_range(FRAME_SIDE_MAX + 1, SIDE_ALL));
               write_reg(REG_FRAME_HEIGHT, SIDE_ALL);
            end
            default: begin
               write_reg(REG_FRAME_WIDTH, pick_side());
               write_reg(REG_FRAME_HEIGHT, pick_side());
            end
         endcase
         write_reg(REG_TRANSPARENT_MASK, pick_mask());
         phase_start = n_sent;
         if (phase == 1 || phase == 3) play_sprite(1'b1);
         while (n_sent - phase_start < PHASE_WORDS) begin
            play_sprite(1'b0);
            // Drop the sender once until the pipe is empty
            if (phase == PHASES - 1 && !paused && n_sent - phase_start >= PHASE_WORDS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      wait_drained();
      if (pending_writes.size() != 0) begin
         n_errors++;
         $error("%0d framebuffer write words never arrived", pending_writes.size());
      end
      $display("Run covered %0d pixel words over %0d register writes: %0d writes, %0d clipped,",
               n_sent, n_reg_writes, n_fb_writes, n_clipped);
      $display("%0d color-keyed and %0d sprite ends, with random stalls on both sides.",
               n_keyed, n_sprite_ends);
      if (n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard stop in case a handshake hangs
   initial begin
      #(TIMEOUT);
      $display("Timeout with %0d write words still expected", pending_writes.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
